// File: rtl/core/lcfq_pkg.sv
`timescale 1ns / 1ps

package lcfq_pkg;

    // Field widths
    localparam int unsigned CoordW  = 32;
    localparam int unsigned ColorW  = 16;
    localparam int unsigned WidthW  = 31;

    // Configuration register indexes
    localparam int unsigned CfgIdxW = 2;
    localparam logic [CfgIdxW-1:0] CfgCamX = 2'd0;
    localparam logic [CfgIdxW-1:0] CfgCamY = 2'd1;
    localparam logic [CfgIdxW-1:0] CfgCamZ = 2'd2;

    // Vertices per quad
    localparam int unsigned NumVerts = 6;
    localparam int unsigned VertIdxW = 3;

    // Internal arithmetic widths
    localparam int unsigned DiffW   = 34;  // d and e before fitting
    localparam int unsigned DMagW   = 33;  // magnitude of d and e
    localparam int unsigned OpW     = 31;  // fitted signed operand
    localparam int unsigned NormW   = 30;  // normalized magnitude
    localparam int unsigned ProdW   = 62;  // signed partial cross product
    localparam int unsigned CrossW  = 63;  // signed cross product
    localparam int unsigned CMagW   = 61;  // cross product magnitude
    localparam int unsigned PosW    = 6;   // leading-one position
    localparam int unsigned AmtW    = 5;   // normalize shift amount
    localparam int unsigned SqW     = 60;  // square of a normalized magnitude
    localparam int unsigned MtW     = 61;  // magnitude times thickness
    localparam int unsigned Len2W   = 62;  // squared length
    localparam int unsigned RootW   = 31;  // length, one bit per root step
    localparam int unsigned NumW    = 62;  // rounding numerator
    localparam int unsigned DenW    = 32;  // twice the length
    localparam int unsigned QuoW    = 31;  // quotient, one bit per divide step
    localparam int unsigned SideW   = 32;  // signed side component

    typedef logic signed [CoordW-1:0] t_coord;

    typedef struct packed {
        logic signed [CoordW-1:0] start_x;
        logic signed [CoordW-1:0] start_y;
        logic signed [CoordW-1:0] start_z;
        logic signed [CoordW-1:0] end_x;
        logic signed [CoordW-1:0] end_y;
        logic signed [CoordW-1:0] end_z;
        logic [ColorW-1:0]        red_in;
        logic [ColorW-1:0]        green_in;
        logic [ColorW-1:0]        blue_in;
        logic [WidthW-1:0]        width_in;
        logic                     on_top_in;
    } t_seg;

    typedef struct packed {
        t_seg                     seg;
        logic signed [SideW-1:0]  side_x;
        logic signed [SideW-1:0]  side_y;
        logic signed [SideW-1:0]  side_z;
    } t_quad;

    typedef struct packed {
        logic signed [CoordW-1:0] vert_x;
        logic signed [CoordW-1:0] vert_y;
        logic signed [CoordW-1:0] vert_z;
        logic [ColorW-1:0]        red_out;
        logic [ColorW-1:0]        green_out;
        logic [ColorW-1:0]        blue_out;
        logic                     on_top_out;
        logic                     last_vertex;
    } t_vert;

endpackage

// File: rtl/core/lcfq_if.sv
`timescale 1ns / 1ps

// Segment channel
interface lcfq_seg_if;
    import lcfq_pkg::*;
    logic valid;
    logic ready;
    t_seg payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// Vertex channel
interface lcfq_vert_if;
    import lcfq_pkg::*;
    logic  valid;
    logic  ready;
    t_vert payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// File: rtl/core/lcfq_side.sv
`timescale 1ns / 1ps

// Side vector pipeline: cross product, normalize, square root, rounded divide.
module lcfq_side import lcfq_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_adv,
    input  logic   i_vld,
    input  t_seg   i_seg,
    input  t_coord i_cam_x,
    input  t_coord i_cam_y,
    input  t_coord i_cam_z,
    output logic   o_vld,
    output t_quad  o_quad
);

    localparam int unsigned FrontStg = 9;
    localparam int unsigned NumStg   = FrontStg + RootW + 1 + QuoW + 1;
    localparam int unsigned RemKeepW = RootW + 1;
    localparam int unsigned SqCurW   = RootW + 3;
    localparam int unsigned DvCurW   = DenW + 1;

    typedef struct packed {
        logic [2:0] sgn;
        logic       zero;
    } t_ctl;

    function automatic logic [DMagW-1:0] mag_d(logic signed [DiffW-1:0] v);
        mag_d = v[DiffW-1] ? DMagW'(-v) : DMagW'(v);
    endfunction

    function automatic logic [1:0] fit_shift(logic [DMagW-1:0] m);
        if (m[DMagW-1])      fit_shift = 2'd3;
        else if (m[DMagW-2]) fit_shift = 2'd2;
        else if (m[DMagW-3]) fit_shift = 2'd1;
        else                 fit_shift = 2'd0;
    endfunction

    function automatic logic signed [OpW-1:0] fit_op(logic signed [DiffW-1:0] v,
                                                    logic [1:0] k);
        logic [NormW-1:0] f;
        f = NormW'(mag_d(v) >> k);
        fit_op = v[DiffW-1] ? -$signed({1'b0, f}) : $signed({1'b0, f});
    endfunction

    // Valid bits and segment data travel with every stage
    logic [NumStg-1:0] r_vld;
    t_seg              r_seg [NumStg];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_adv) begin
            r_vld <= {r_vld[NumStg-2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_seg[0] <= i_seg;
            for (int i = 1; i < NumStg; i++) begin
                r_seg[i] <= r_seg[i-1];
            end
        end
    end

    // Stage 0: direction and doubled midpoint-to-camera vector
    logic signed [DiffW-1:0] r_d [3];
    logic signed [DiffW-1:0] r_e [3];

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_d[0] <= DiffW'(i_seg.end_x) - DiffW'(i_seg.start_x);
            r_d[1] <= DiffW'(i_seg.end_y) - DiffW'(i_seg.start_y);
            r_d[2] <= DiffW'(i_seg.end_z) - DiffW'(i_seg.start_z);
            r_e[0] <= (DiffW'(i_cam_x) <<< 1) - DiffW'(i_seg.start_x) - DiffW'(i_seg.end_x);
            r_e[1] <= (DiffW'(i_cam_y) <<< 1) - DiffW'(i_seg.start_y) - DiffW'(i_seg.end_y);
            r_e[2] <= (DiffW'(i_cam_z) <<< 1) - DiffW'(i_seg.start_z) - DiffW'(i_seg.end_z);
        end
    end

    // Stage 1: fit both vectors below 2^30
    logic [1:0]            w_dk, w_ek;
    logic signed [OpW-1:0] r_fd [3];
    logic signed [OpW-1:0] r_fe [3];

    always_comb begin
        w_dk = fit_shift(mag_d(r_d[0]) | mag_d(r_d[1]) | mag_d(r_d[2]));
        w_ek = fit_shift(mag_d(r_e[0]) | mag_d(r_e[1]) | mag_d(r_e[2]));
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int i = 0; i < 3; i++) begin
                r_fd[i] <= fit_op(r_d[i], w_dk);
                r_fe[i] <= fit_op(r_e[i], w_ek);
            end
        end
    end

    // Stage 2: partial products of the cross product
    logic signed [ProdW-1:0] r_p [6];

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_p[0] <= r_fd[1] * r_fe[2];
            r_p[1] <= r_fd[2] * r_fe[1];
            r_p[2] <= r_fd[2] * r_fe[0];
            r_p[3] <= r_fd[0] * r_fe[2];
            r_p[4] <= r_fd[0] * r_fe[1];
            r_p[5] <= r_fd[1] * r_fe[0];
        end
    end

    // Stage 3: cross product
    logic signed [CrossW-1:0] r_c [3];

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int i = 0; i < 3; i++) begin
                r_c[i] <= CrossW'(r_p[2*i]) - CrossW'(r_p[2*i+1]);
            end
        end
    end

    // Stage 4: magnitudes, signs, combined magnitude word
    logic [CMagW-1:0] r_cm4 [3];
    logic [CMagW-1:0] r_cor;
    t_ctl             r_ctl4;
    logic [CMagW-1:0] w_cm [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_cm[i] = r_c[i][CrossW-1] ? CMagW'(-r_c[i]) : CMagW'(r_c[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int i = 0; i < 3; i++) begin
                r_cm4[i]      <= w_cm[i];
                r_ctl4.sgn[i] <= r_c[i][CrossW-1];
            end
            r_cor       <= w_cm[0] | w_cm[1] | w_cm[2];
            r_ctl4.zero <= (w_cm[0] | w_cm[1] | w_cm[2]) == '0;
        end
    end

    // Stage 5: find the leading one, choose the normalize shift
    logic [PosW-1:0]  w_pos;
    logic [CMagW-1:0] r_cm5 [3];
    logic             r_rsh;
    logic [AmtW-1:0]  r_amt;
    t_ctl             r_ctl5;

    always_comb begin
        w_pos = '0;
        for (int i = 0; i < CMagW; i++) begin
            if (r_cor[i]) begin
                w_pos = PosW'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_cm5  <= r_cm4;
            r_ctl5 <= r_ctl4;
            if (w_pos > PosW'(NormW - 1)) begin
                r_rsh <= 1'b1;
                r_amt <= AmtW'(w_pos - PosW'(NormW - 1));
            end else begin
                r_rsh <= 1'b0;
                r_amt <= AmtW'(PosW'(NormW - 1) - w_pos);
            end
        end
    end

    // Stage 6: bring the largest magnitude into [2^29, 2^30)
    logic [NormW-1:0] r_nm [3];
    t_ctl             r_ctl6;

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_ctl6 <= r_ctl5;
            for (int i = 0; i < 3; i++) begin
                r_nm[i] <= r_rsh ? NormW'(r_cm5[i] >> r_amt) : NormW'(r_cm5[i] << r_amt);
            end
        end
    end

    // Stage 7: squares and magnitude times thickness
    logic [SqW-1:0] r_sq [3];
    logic [MtW-1:0] r_mt [3];
    t_ctl           r_ctl7;

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_ctl7 <= r_ctl6;
            for (int i = 0; i < 3; i++) begin
                r_sq[i] <= r_nm[i] * r_nm[i];
                r_mt[i] <= r_nm[i] * r_seg[6].width_in;
            end
        end
    end

    // Stage 8 and root steps: squared length, then one root bit per stage
    logic [Len2W-1:0]    r_sq_val  [RootW+1];
    logic [RemKeepW-1:0] r_sq_rem  [RootW+1];
    logic [RootW-1:0]    r_sq_root [RootW+1];
    logic [MtW-1:0]      r_sq_mt   [RootW+1][3];
    t_ctl                r_sq_ctl  [RootW+1];
    logic [SqCurW-1:0]   w_sq_cur  [RootW];
    logic                w_sq_ge   [RootW];

    always_comb begin
        for (int k = 0; k < RootW; k++) begin
            w_sq_cur[k] = {r_sq_rem[k], r_sq_val[k][Len2W-1 -: 2]};
            w_sq_ge[k]  = w_sq_cur[k] >= {1'b0, r_sq_root[k], 2'b01};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_sq_val[0]  <= Len2W'(r_sq[0]) + Len2W'(r_sq[1]) + Len2W'(r_sq[2]);
            r_sq_rem[0]  <= '0;
            r_sq_root[0] <= '0;
            r_sq_mt[0]   <= r_mt;
            r_sq_ctl[0]  <= r_ctl7;
            for (int k = 1; k <= RootW; k++) begin
                r_sq_val[k] <= r_sq_val[k-1] << 2;
                r_sq_mt[k]  <= r_sq_mt[k-1];
                r_sq_ctl[k] <= r_sq_ctl[k-1];
                if (w_sq_ge[k-1]) begin
                    r_sq_rem[k]  <= RemKeepW'(w_sq_cur[k-1]
                                              - {1'b0, r_sq_root[k-1], 2'b01});
                    r_sq_root[k] <= {r_sq_root[k-1][RootW-2:0], 1'b1};
                end else begin
                    r_sq_rem[k]  <= RemKeepW'(w_sq_cur[k-1]);
                    r_sq_root[k] <= {r_sq_root[k-1][RootW-2:0], 1'b0};
                end
            end
        end
    end

    // Rounding numerator setup, then one quotient bit per stage
    logic [NumW-1:0]   w_num    [3];
    logic [DenW-1:0]   r_dv_rem [QuoW+1][3];
    logic [QuoW-1:0]   r_dv_num [QuoW+1][3];
    logic [QuoW-1:0]   r_dv_quo [QuoW+1][3];
    logic [DenW-1:0]   r_dv_den [QuoW+1];
    t_ctl              r_dv_ctl [QuoW+1];
    logic [DvCurW-1:0] w_dv_cur [QuoW][3];
    logic              w_dv_ge  [QuoW][3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_num[i] = NumW'(r_sq_mt[RootW][i]) + NumW'(r_sq_root[RootW]);
        end
        for (int j = 0; j < QuoW; j++) begin
            for (int i = 0; i < 3; i++) begin
                w_dv_cur[j][i] = {r_dv_rem[j][i], r_dv_num[j][i][QuoW-1]};
                w_dv_ge[j][i]  = w_dv_cur[j][i] >= {1'b0, r_dv_den[j]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_dv_den[0] <= {r_sq_root[RootW], 1'b0};
            r_dv_ctl[0] <= r_sq_ctl[RootW];
            for (int i = 0; i < 3; i++) begin
                r_dv_rem[0][i] <= DenW'(w_num[i] >> QuoW);
                r_dv_num[0][i] <= w_num[i][QuoW-1:0];
                r_dv_quo[0][i] <= '0;
            end
            for (int j = 1; j <= QuoW; j++) begin
                r_dv_den[j] <= r_dv_den[j-1];
                r_dv_ctl[j] <= r_dv_ctl[j-1];
                for (int i = 0; i < 3; i++) begin
                    r_dv_num[j][i] <= r_dv_num[j-1][i] << 1;
                    r_dv_quo[j][i] <= {r_dv_quo[j-1][i][QuoW-2:0], w_dv_ge[j-1][i]};
                    if (w_dv_ge[j-1][i]) begin
                        r_dv_rem[j][i] <= DenW'(w_dv_cur[j-1][i] - {1'b0, r_dv_den[j-1]});
                    end else begin
                        r_dv_rem[j][i] <= DenW'(w_dv_cur[j-1][i]);
                    end
                end
            end
        end
    end

    // Last stage: apply signs, or fall back to half thickness along x
    logic signed [SideW-1:0] w_s [3];
    logic signed [SideW-1:0] r_s [3];
    t_ctl                    w_fctl;
    logic [WidthW:0]         w_half;

    always_comb begin
        w_fctl = r_dv_ctl[QuoW];
        w_half = ((WidthW+1)'(r_seg[NumStg-2].width_in) + 1'b1) >> 1;
        for (int i = 0; i < 3; i++) begin
            w_s[i] = w_fctl.sgn[i] ? -$signed({1'b0, r_dv_quo[QuoW][i]})
                                   : $signed({1'b0, r_dv_quo[QuoW][i]});
        end
        if (w_fctl.zero) begin
            w_s[0] = $signed(SideW'(w_half));
            w_s[1] = '0;
            w_s[2] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_s <= w_s;
        end
    end

    assign o_vld         = r_vld[NumStg-1];
    assign o_quad.seg    = r_seg[NumStg-1];
    assign o_quad.side_x = r_s[0];
    assign o_quad.side_y = r_s[1];
    assign o_quad.side_z = r_s[2];

endmodule

// File: rtl/core/line_to_camera_facing_quad.sv
`timescale 1ns / 1ps

// Channel   Dir  Payload  Transaction
// i_seg     in   t_seg    one line segment, valid & ready
// o_vert    out  t_vert   one vertex, valid & ready, six per segment
// i_cfg_*   in   camera   one register write when i_cfg_wr_en is high
//
// A segment runs through a 73-stage side-vector pipeline (cross product,
// normalize, one-bit-per-stage square root and divide); the emitter sends
// its six vertices one per cycle while o_vert is ready, quad after quad.
// Reset is synchronous, active low, and empties every stage.
// A stall on o_vert holds the output register; the pipeline and i_seg.ready
// drop together until the emitter frees up, so nothing is lost or repeated.
module line_to_camera_facing_quad import lcfq_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    lcfq_seg_if.sink           i_seg,
    lcfq_vert_if.source        o_vert,
    input  logic               i_cfg_wr_en,
    input  logic [CfgIdxW-1:0] i_cfg_index,
    input  logic [CoordW-1:0]  i_cfg_wdata
);

    // Camera registers
    t_coord r_cam_x, r_cam_y, r_cam_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cam_x <= '0;
            r_cam_y <= '0;
            r_cam_z <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CfgCamX: r_cam_x <= i_cfg_wdata;
                CfgCamY: r_cam_y <= i_cfg_wdata;
                CfgCamZ: r_cam_z <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Side vector pipeline
    logic  w_adv;
    logic  w_side_vld;
    t_quad w_side_quad;

    lcfq_side u_side (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_vld   (i_seg.valid),
        .i_seg   (i_seg.payload),
        .i_cam_x (r_cam_x),
        .i_cam_y (r_cam_y),
        .i_cam_z (r_cam_z),
        .o_vld   (w_side_vld),
        .o_quad  (w_side_quad)
    );

    // Emitter and output register handshake
    logic                r_em_vld;
    t_quad               r_em;
    logic [VertIdxW-1:0] r_em_cnt;
    logic                r_out_vld;
    t_vert               r_out;
    logic                w_out_free, w_em_fire, w_em_done, w_em_load_ok;

    assign w_out_free   = !r_out_vld || o_vert.ready;
    assign w_em_fire    = r_em_vld && w_out_free;
    assign w_em_done    = w_em_fire && (r_em_cnt == VertIdxW'(NumVerts - 1));
    assign w_em_load_ok = !r_em_vld || w_em_done;
    assign w_adv        = !w_side_vld || w_em_load_ok;
    assign i_seg.ready  = w_adv;

    function automatic t_coord sat_add(t_coord base, logic signed [SideW-1:0] side,
                                       logic neg);
        logic signed [CoordW+1:0] sum;
        sum = neg ? ((CoordW+2)'(base) - (CoordW+2)'(side))
                  : ((CoordW+2)'(base) + (CoordW+2)'(side));
        if (sum > (CoordW+2)'($signed({1'b0, {(CoordW-1){1'b1}}}))) begin
            sat_add = {1'b0, {(CoordW-1){1'b1}}};
        end else if (sum < (CoordW+2)'($signed({1'b1, {(CoordW-1){1'b0}}}))) begin
            sat_add = {1'b1, {(CoordW-1){1'b0}}};
        end else begin
            sat_add = CoordW'(sum);
        end
    endfunction

    // Pick the corner: a-s, a+s, b+s, a-s, b+s, b-s
    logic  w_use_b, w_neg;
    t_vert w_vert;

    always_comb begin
        w_use_b = (r_em_cnt == 3'd2) || (r_em_cnt == 3'd4) || (r_em_cnt == 3'd5);
        w_neg   = (r_em_cnt == 3'd0) || (r_em_cnt == 3'd3) || (r_em_cnt == 3'd5);
        w_vert.vert_x      = sat_add(w_use_b ? r_em.seg.end_x : r_em.seg.start_x,
                                     r_em.side_x, w_neg);
        w_vert.vert_y      = sat_add(w_use_b ? r_em.seg.end_y : r_em.seg.start_y,
                                     r_em.side_y, w_neg);
        w_vert.vert_z      = sat_add(w_use_b ? r_em.seg.end_z : r_em.seg.start_z,
                                     r_em.side_z, w_neg);
        w_vert.red_out     = r_em.seg.red_in;
        w_vert.green_out   = r_em.seg.green_in;
        w_vert.blue_out    = r_em.seg.blue_in;
        w_vert.on_top_out  = r_em.seg.on_top_in;
        w_vert.last_vertex = r_em_cnt == VertIdxW'(NumVerts - 1);
    end

    // Load a quad, advance the corner count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_em_vld <= 1'b0;
            r_em_cnt <= '0;
        end else if (w_side_vld && w_em_load_ok) begin
            r_em_vld <= 1'b1;
            r_em_cnt <= '0;
        end else if (w_em_done) begin
            r_em_vld <= 1'b0;
            r_em_cnt <= '0;
        end else if (w_em_fire) begin
            r_em_cnt <= r_em_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_side_vld && w_em_load_ok) begin
            r_em <= w_side_quad;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_out_free) begin
            r_out_vld <= r_em_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_em_fire) begin
            r_out <= w_vert;
        end
    end

    assign o_vert.valid   = r_out_vld;
    assign o_vert.payload = r_out;

`ifndef SYNTHESIS
    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_side_vld && !w_adv |=> w_side_vld)
        else $error("side pipeline dropped a stalled quad");

    a_stall_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |-> r_em_vld && !w_em_done)
        else $error("pipeline stalled with a free emitter");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_em_cnt < VertIdxW'(NumVerts))
        else $error("corner count out of range");

    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_em_done |=> r_em_cnt == '0)
        else $error("corner count did not restart after the last vertex");

    a_last_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_em_fire |=> r_out.last_vertex == $past(r_em_cnt == VertIdxW'(NumVerts - 1)))
        else $error("last flag does not match the sixth corner");
`endif

endmodule
